>>> rtl/core/positional_list_engine_defines.svh
// Assertion macros shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLE_ASSERT(lbl, clk, rstn, prop, msg)
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_POS = 3'd0,
    ACT_INS_END = 3'd1,
    ACT_REM_POS = 3'd2,
    ACT_REM_END = 3'd3,
    ACT_DUMP    = 3'd4
  } ple_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } ple_status_e;

  typedef enum logic [2:0] {
    RES_INS_OK,
    RES_FULL,
    RES_REM_OK,
    RES_EMPTY,
    RES_DUMP
  } ple_res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_GATHER,
    S_REM,
    S_DUMP
  } ple_state_e;

  typedef struct packed {
    logic     capture;
    logic     gather;
    logic     ins;
    logic     rem;
    logic     rot;
    logic     out_load;
    ple_res_e res;
  } ple_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
    logic out_free;
  } ple_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ple_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ple_in_if;
  import ple_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [POS_W-1:0]    position;
  logic [HANDLE_W-1:0]        record_handle;

  modport source (output valid, output action, output position, output record_handle,
                  input ready);
  modport sink (input valid, input action, input position, input record_handle,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/ple_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ple_out_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [INDEX_W-1:0]  out_index;
  logic [COUNT_W-1:0]  entry_count;
  logic                last_of_run;

  modport source (output valid, output status, output out_handle, output out_index,
                  output entry_count, output last_of_run, input ready);
  modport sink (input valid, input status, input out_handle, input out_index,
                input entry_count, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ple_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_defines.svh"

module ple_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ple_pkg::ACTION_W-1:0]  in_action_i,
  output logic                          in_ready_o,
  input  ple_pkg::ple_sts_t             sts_i,
  output ple_pkg::ple_cmd_t             cmd_o
);
  import ple_pkg::*;

  ple_state_e state_q, state_d;
  logic       ins_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ins_accept = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (ple_action_e'(in_action_i)) inside
            ACT_INS_POS, ACT_INS_END: begin
              state_d    = S_INS;
              ins_accept = 1'b1;
            end
            ACT_REM_POS, ACT_REM_END: state_d = S_GATHER;
            ACT_DUMP:                 state_d = S_DUMP;
            default:                  state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins      = !sts_i.full;
          cmd_o.out_load = 1'b1;
          cmd_o.res      = sts_i.full ? RES_FULL : RES_INS_OK;
          state_d        = S_IDLE;
        end
      end
      S_GATHER: begin
        cmd_o.gather = 1'b1;
        state_d      = S_REM;
      end
      S_REM: begin
        if (sts_i.out_free) begin
          cmd_o.rem      = !sts_i.empty;
          cmd_o.out_load = 1'b1;
          cmd_o.res      = sts_i.empty ? RES_EMPTY : RES_REM_OK;
          state_d        = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts_i.empty) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.rot      = 1'b1;
          cmd_o.res      = RES_DUMP;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `PLE_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free, "result overwritten")
  `PLE_ASSERT(a_ins_room, clk_i, rst_ni, cmd_o.ins |-> !sts_i.full, "insert into full list")
  `PLE_ASSERT(a_ins_busy, clk_i, rst_ni, ins_accept |=> !in_ready_o, "item taken during insert")

endmodule

`default_nettype wire

>>> rtl/core/ple_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_defines.svh"

module ple_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ple_pkg::ACTION_W-1:0]      action_i,
  input  logic signed [ple_pkg::POS_W-1:0]  position_i,
  input  logic [ple_pkg::HANDLE_W-1:0]      record_handle_i,
  input  ple_pkg::ple_cmd_t                 cmd_i,
  output ple_pkg::ple_sts_t                 sts_o,
  ple_out_if.source                         res_o
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int GRP   = 8;
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

  logic [HANDLE_W-1:0] cell_q [CAPACITY];
  logic [HANDLE_W-1:0] cell_d [CAPACITY];
  logic [HANDLE_W-1:0] part_q [NGRP];
  logic [HANDLE_W-1:0] part_d [NGRP];
  logic [HANDLE_W-1:0] pick;
  logic [HANDLE_W-1:0] handle_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    at_q, at_d;
  logic [CNT_W-1:0]    hi;
  logic [CNT_W-1:0]    last_pos;
  logic [POS_W-1:0]    pos_u;
  logic [IDX_W-1:0]    k_q, k_d;
  logic                empty, full, dump_last;

  logic                valid_q, valid_d;
  ple_status_e         status_q, status_d;
  logic [HANDLE_W-1:0] ohandle_q, ohandle_d;
  logic [INDEX_W-1:0]  oindex_q, oindex_d;
  logic [COUNT_W-1:0]  ocount_q, ocount_d;
  logic                olast_q, olast_d;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign last_pos  = count_q - 1'b1;
  assign dump_last = (CNT_W'(k_q) == last_pos);

  assign sts_o.empty     = empty;
  assign sts_o.full      = full;
  assign sts_o.dump_last = dump_last;
  assign sts_o.out_free  = !valid_q || res_o.ready;

  // clamp the requested position against the current count
  always_comb begin
    pos_u = position_i;
    hi    = '0;
    at_d  = '0;
    unique case (ple_action_e'(action_i)) inside
      ACT_INS_POS: hi = count_q;
      ACT_REM_POS: hi = empty ? '0 : last_pos;
      default:     hi = '0;
    endcase
    unique case (ple_action_e'(action_i)) inside
      ACT_INS_POS, ACT_REM_POS: begin
        if (position_i[POS_W-1] || (position_i == '0)) begin
          at_d = '0;
        end else if (pos_u >= POS_W'(hi)) begin
          at_d = hi;
        end else begin
          at_d = CNT_W'(pos_u);
        end
      end
      ACT_INS_END: at_d = count_q;
      ACT_REM_END: at_d = empty ? '0 : last_pos;
      default:     at_d = '0;
    endcase
  end

  // shift, insert or rotate every cell in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.ins) begin
        if (CNT_W'(i) == at_q) begin
          cell_d[i] = handle_q;
        end else if ((i > 0) && (CNT_W'(i) > at_q)) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.rem) begin
        if ((i < CAPACITY - 1) && (CNT_W'(i) >= at_q)) begin
          cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (cmd_i.rot) begin
        if (CNT_W'(i) == last_pos) begin
          cell_d[i] = cell_q[0];
        end else if ((i < CAPACITY - 1) && (CNT_W'(i) < last_pos)) begin
          cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // first level of the selection tree, one partial per group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if ((g * GRP + j < CAPACITY) && (CNT_W'(g * GRP + j) == at_q)) begin
          part_d[g] = part_d[g] | cell_q[(g * GRP + j < CAPACITY) ? g * GRP + j : 0];
        end
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int g = 0; g < NGRP; g++) begin
      pick = pick | part_q[g];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.rem) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.capture) begin
      k_d = '0;
    end else if (cmd_i.rot) begin
      k_d = k_q + 1'b1;
    end
  end

  always_comb begin
    status_d  = status_q;
    ohandle_d = ohandle_q;
    oindex_d  = oindex_q;
    ocount_d  = ocount_q;
    olast_d   = olast_q;
    valid_d   = valid_q && !res_o.ready;
    if (cmd_i.out_load) begin
      valid_d   = 1'b1;
      ohandle_d = '0;
      oindex_d  = '0;
      ocount_d  = COUNT_W'(count_d);
      olast_d   = 1'b1;
      unique case (cmd_i.res)
        RES_INS_OK: status_d = ST_OK;
        RES_FULL:   status_d = ST_FULL;
        RES_REM_OK: begin
          status_d  = ST_OK;
          ohandle_d = pick;
        end
        RES_EMPTY:  status_d = ST_EMPTY;
        RES_DUMP: begin
          status_d  = ST_OK;
          ohandle_d = cell_q[0];
          oindex_d  = INDEX_W'(k_q);
          olast_d   = dump_last;
        end
        default:    status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q    <= cell_d;
    status_q  <= status_d;
    ohandle_q <= ohandle_d;
    oindex_q  <= oindex_d;
    ocount_q  <= ocount_d;
    olast_q   <= olast_d;
    if (cmd_i.capture) begin
      at_q     <= at_d;
      handle_q <= record_handle_i;
    end
    if (cmd_i.gather) begin
      part_q <= part_d;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.status      = status_q;
  assign res_o.out_handle  = ohandle_q;
  assign res_o.out_index   = oindex_q;
  assign res_o.entry_count = ocount_q;
  assign res_o.last_of_run = olast_q;

  `PLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count beyond capacity")
  `PLE_ASSERT(a_ins_count, clk_i, rst_ni, cmd_i.ins |=> (count_q == $past(count_q) + 1'b1), "insert lost count")
  `PLE_ASSERT(a_rem_count, clk_i, rst_ni, cmd_i.rem |=> (count_q == $past(count_q) - 1'b1), "remove lost count")
  `PLE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !res_o.valid, "result shown in reset")

endmodule

`default_nettype wire

>>> rtl/core/positional_list_engine.sv
// Channel   Port      Dir  Payload
// --------  --------  ---  ------------------------------------------------------
// request   item_i    in   action, position, record_handle
// result    result_o  out  status, out_handle, out_index, entry_count, last_of_run
//
// Insert: capture, then a shift of all cells in parallel as the result loads.
// Remove: capture, gather, remove; the removed entry is picked through a
// registered two-level tree over the cells. Dump: capture, then one result per
// cycle while results are taken; empty dumps and unused actions give no result.
// Reset clears the count and control only; no clearing pass is run.
// A stalled result holds the engine; the next item is taken once the last
// result of the current one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_in_if.sink     item_i,
  ple_out_if.source  result_o
);
  import ple_pkg::*;

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_action_i (item_i.action),
    .in_ready_o  (item_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ple_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (item_i.action),
    .position_i      (item_i.position),
    .record_handle_i (item_i.record_handle),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_o           (result_o)
  );

endmodule

`default_nettype wire
